// ===== rtl/core/rmq_pkg.sv =====
`timescale 1ns / 1ps

package rmq_pkg;

    // Fixed point format: ONE means 1.0
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int OUT_MAX   = (ONE < 32767) ? ONE : 32767;

    // Radicand: signed working width, positive (clamped) width
    localparam int RAD_W  = IN_W + 3;
    localparam int RADU_W = IN_W + 1;

    // First root: radicand scaled by ONE, digit pairs
    localparam int SQ1_W = ((RADU_W + FRAC_BITS + 1) / 2) * 2;
    localparam int R1_W  = SQ1_W / 2;

    // Off-diagonal terms and the first divide
    localparam int MAG_W = IN_W + 1;
    localparam int N1_W  = MAG_W + FRAC_BITS + 1;
    localparam int D1_W  = R1_W + 2;
    localparam int Q1_W  = MAG_W - 1 + FRAC_BITS / 2;
    localparam int C_W   = Q1_W + 1;

    // Norm root and the second divide
    localparam int SQ2_W = 2 * Q1_W;
    localparam int R2_W  = SQ2_W / 2;
    localparam int N2_W  = Q1_W + FRAC_BITS + 1;
    localparam int D2_W  = R2_W + 1;
    localparam int Q2_W  = FRAC_BITS + 1;

    localparam int LANES = 4;

    typedef struct packed {
        logic signed [IN_W-1:0] r00;
        logic signed [IN_W-1:0] r01;
        logic signed [IN_W-1:0] r02;
        logic signed [IN_W-1:0] r10;
        logic signed [IN_W-1:0] r11;
        logic signed [IN_W-1:0] r12;
        logic signed [IN_W-1:0] r20;
        logic signed [IN_W-1:0] r21;
        logic signed [IN_W-1:0] r22;
    } t_mat;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_w;
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
    } t_quat;

    // Branch: which component owns the root
    typedef enum logic [1:0] {
        OWN_W = 2'd0,
        OWN_X = 2'd1,
        OWN_Y = 2'd2,
        OWN_Z = 2'd3
    } t_own;

    typedef logic [LANES-1:0][MAG_W-1:0] t_num4;

    typedef struct packed {
        t_own  own;
        t_num4 num;
    } t_s1_side;

    typedef struct packed {
        t_own             own;
        logic [Q1_W-1:0]  own_c;
        logic [LANES-1:0] neg;
    } t_d1_side;

    typedef logic [LANES-1:0][C_W-1:0] t_s2_side;

    typedef logic [LANES-1:0] t_d2_side;

endpackage

// ===== rtl/core/rmq_stream_if.sv =====
`timescale 1ns / 1ps

// Valid/ready channel carrying one word
interface rmq_stream_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rmq_sqrt_cell.sv =====
`timescale 1ns / 1ps

// One digit-pair step of an integer square root
module rmq_sqrt_cell #(
    parameter int  W      = 32,
    parameter type t_side = logic
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [W/2+1:0] i_rem,
    input  logic [W/2-1:0] i_root,
    input  logic [W-1:0]   i_rad,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [W/2+1:0] o_rem,
    output logic [W/2-1:0] o_root,
    output logic [W-1:0]   o_rad,
    output t_side          o_side
);
    localparam int RW  = W / 2;
    localparam int RMW = RW + 2;

    logic           r_valid;
    logic [RMW-1:0] r_rem;
    logic [RW-1:0]  r_root;
    logic [W-1:0]   r_rad;
    t_side          r_side;

    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           fit;
    logic [RMW-1:0] n_rem;
    logic [RW-1:0]  n_root;

    // bring down two bits, try root*4+1
    always_comb begin
        rem_sh = {i_rem[RMW-3:0], i_rad[W-1:W-2]};
        trial  = {i_root, 2'b01};
        fit    = (rem_sh >= trial);
        n_rem  = fit ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[RW-2:0], fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[W-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

// ===== rtl/core/rmq_div_cell.sv =====
`timescale 1ns / 1ps

// One quotient bit of a restoring divide
module rmq_div_cell #(
    parameter int  Q      = 23,
    parameter int  DW     = 18,
    parameter type t_side = logic
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [Q-1:0]  i_num,
    input  logic [DW-1:0] i_den,
    input  logic [Q-1:0]  i_quo,
    input  t_side         i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [Q-1:0]  o_num,
    output logic [DW-1:0] o_den,
    output logic [Q-1:0]  o_quo,
    output t_side         o_side
);
    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [Q-1:0]  r_num;
    logic [DW-1:0] r_den;
    logic [Q-1:0]  r_quo;
    t_side         r_side;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          fit;
    logic [DW-1:0] n_rem;

    // shift in next numerator bit, subtract if it fits
    always_comb begin
        rem_sh = {i_rem, i_num[Q-1]};
        diff   = rem_sh - {1'b0, i_den};
        fit    = (rem_sh >= {1'b0, i_den});
        n_rem  = fit ? diff[DW-1:0] : rem_sh[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= {i_num[Q-2:0], 1'b0};
            r_den  <= i_den;
            r_quo  <= {i_quo[Q-2:0], fit};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps

// Rotation matrix to unit quaternion (Shepperd). Takes one 3x3 matrix word per
// cycle and returns w,x,y,z in the same Q.14 format. The
// datapath is a single pipeline of bit-step cells: a 16-cell root chain, a
// 23-cell divide chain per component, a 23-cell norm root chain and a 15-cell
// normalizing divide chain per component, plus seven plain stages. A stall
// at the output holds the whole pipeline; otherwise a new word enters every
// cycle. Non-rotation input that gives a non-positive radicand is clamped to
// the smallest positive radicand; outputs saturate to [-1.0, 1.0].
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmq_stream_if.sink   i_mat,
    rmq_stream_if.source o_quat
);
    localparam logic signed [RAD_W-1:0] RAD_ONE = RAD_W'(ONE);
    localparam logic [Q2_W-1:0]         SAT_MAG = Q2_W'(OUT_MAX);

    logic en;

    // ---------------- stage A: branch, radicand, numerators
    t_mat                     d;
    logic signed [RAD_W-1:0]  e00, e11, e22, trace, rad;
    logic signed [MAG_W-1:0]  d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
    logic [RADU_W-1:0]        radu;
    t_own                     own;
    t_num4                    num;

    logic                     r_a_valid;
    logic [RADU_W-1:0]        r_a_rad;
    t_s1_side                 r_a_side;

    always_comb begin
        d      = i_mat.data;
        e00    = RAD_W'(d.r00);
        e11    = RAD_W'(d.r11);
        e22    = RAD_W'(d.r22);
        trace  = e00 + e11 + e22;
        d21_12 = MAG_W'(d.r21) - MAG_W'(d.r12);
        d02_20 = MAG_W'(d.r02) - MAG_W'(d.r20);
        d10_01 = MAG_W'(d.r10) - MAG_W'(d.r01);
        s01_10 = MAG_W'(d.r01) + MAG_W'(d.r10);
        s02_20 = MAG_W'(d.r02) + MAG_W'(d.r20);
        s12_21 = MAG_W'(d.r12) + MAG_W'(d.r21);
        num    = '0;
        priority if (trace > 0) begin
            own    = OWN_W;
            rad    = RAD_ONE + trace;
            num[1] = d21_12;
            num[2] = d02_20;
            num[3] = d10_01;
        end else if (e00 > e11 && e00 > e22) begin
            own    = OWN_X;
            rad    = RAD_ONE + e00 - e11 - e22;
            num[0] = d21_12;
            num[2] = s01_10;
            num[3] = s02_20;
        end else if (e11 > e22) begin
            own    = OWN_Y;
            rad    = RAD_ONE + e11 - e00 - e22;
            num[0] = d02_20;
            num[1] = s01_10;
            num[3] = s12_21;
        end else begin
            own    = OWN_Z;
            rad    = RAD_ONE + e22 - e00 - e11;
            num[0] = d10_01;
            num[1] = s02_20;
            num[2] = s12_21;
        end
        // not a rotation: clamp to smallest positive radicand
        radu = (rad <= 0) ? RADU_W'(1) : rad[RADU_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rad  <= radu;
            r_a_side <= '{own: own, num: num};
        end
    end

    // ---------------- root chain: floor(sqrt(rad * ONE))
    logic [R1_W:0]                  s1_valid;
    logic [R1_W:0][R1_W+1:0]        s1_rem;
    logic [R1_W:0][R1_W-1:0]        s1_root;
    logic [R1_W:0][SQ1_W-1:0]       s1_rad;
    t_s1_side                       s1_side [R1_W+1];

    assign s1_valid[0] = r_a_valid;
    assign s1_rem[0]   = '0;
    assign s1_root[0]  = '0;
    assign s1_rad[0]   = SQ1_W'({r_a_rad, {FRAC_BITS{1'b0}}});
    assign s1_side[0]  = r_a_side;

    for (genvar k = 0; k < R1_W; k++) begin : g_s1
        rmq_sqrt_cell #(.W(SQ1_W), .t_side(t_s1_side)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s1_valid[k]),
            .i_rem   (s1_rem[k]),
            .i_root  (s1_root[k]),
            .i_rad   (s1_rad[k]),
            .i_side  (s1_side[k]),
            .o_valid (s1_valid[k+1]),
            .o_rem   (s1_rem[k+1]),
            .o_root  (s1_root[k+1]),
            .o_rad   (s1_rad[k+1]),
            .o_side  (s1_side[k+1])
        );
    end

    // ---------------- stage B: divide operands, own component
    t_s1_side                    b_in;
    logic [R1_W-1:0]             root;
    logic [R1_W:0]               root_p1;
    logic [LANES-1:0]            b_neg;
    logic [LANES-1:0][MAG_W-1:0] b_mag;
    logic [LANES-1:0][N1_W-1:0]  n_b_numer;

    logic                        r_b_valid;
    logic [LANES-1:0][N1_W-1:0]  r_b_numer;
    logic [D1_W-1:0]             r_b_den;
    t_d1_side                    r_b_side;

    always_comb begin
        b_in    = s1_side[R1_W];
        root    = s1_root[R1_W];
        root_p1 = {1'b0, root} + 1'b1;
        for (int i = 0; i < LANES; i++) begin
            b_neg[i]     = b_in.num[i][MAG_W-1];
            b_mag[i]     = b_neg[i] ? (MAG_W'(0) - b_in.num[i]) : b_in.num[i];
            // mag * 2 * ONE + 2 * root, over 4 * root
            n_b_numer[i] = {b_mag[i], {(FRAC_BITS + 1){1'b0}}} + N1_W'({root, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= s1_valid[R1_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_numer <= n_b_numer;
            r_b_den   <= {root, 2'b00};
            r_b_side  <= '{own: b_in.own, own_c: Q1_W'(root_p1[R1_W:1]), neg: b_neg};
        end
    end

    // ---------------- first divide chains, one lane per component
    logic [Q1_W:0]                        d1_valid;
    logic [LANES-1:0][Q1_W:0][D1_W-1:0]   d1_rem;
    logic [LANES-1:0][Q1_W:0][Q1_W-1:0]   d1_num;
    logic [LANES-1:0][Q1_W:0][D1_W-1:0]   d1_den;
    logic [LANES-1:0][Q1_W:0][Q1_W-1:0]   d1_quo;
    t_d1_side                             d1_side [Q1_W+1];

    assign d1_valid[0] = r_b_valid;
    assign d1_side[0]  = r_b_side;

    for (genvar l = 0; l < LANES; l++) begin : g_d1_lane
        assign d1_rem[l][0] = D1_W'(r_b_numer[l][N1_W-1:Q1_W]);
        assign d1_num[l][0] = r_b_numer[l][Q1_W-1:0];
        assign d1_den[l][0] = r_b_den;
        assign d1_quo[l][0] = '0;
        for (genvar k = 0; k < Q1_W; k++) begin : g_cell
            if (l == 0) begin : g_lead
                rmq_div_cell #(.Q(Q1_W), .DW(D1_W), .t_side(t_d1_side)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (en),
                    .i_valid (d1_valid[k]),
                    .i_rem   (d1_rem[l][k]),
                    .i_num   (d1_num[l][k]),
                    .i_den   (d1_den[l][k]),
                    .i_quo   (d1_quo[l][k]),
                    .i_side  (d1_side[k]),
                    .o_valid (d1_valid[k+1]),
                    .o_rem   (d1_rem[l][k+1]),
                    .o_num   (d1_num[l][k+1]),
                    .o_den   (d1_den[l][k+1]),
                    .o_quo   (d1_quo[l][k+1]),
                    .o_side  (d1_side[k+1])
                );
            end else begin : g_plain
                rmq_div_cell #(.Q(Q1_W), .DW(D1_W), .t_side(logic)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (en),
                    .i_valid (d1_valid[k]),
                    .i_rem   (d1_rem[l][k]),
                    .i_num   (d1_num[l][k]),
                    .i_den   (d1_den[l][k]),
                    .i_quo   (d1_quo[l][k]),
                    .i_side  (1'b0),
                    .o_valid (),
                    .o_rem   (d1_rem[l][k+1]),
                    .o_num   (d1_num[l][k+1]),
                    .o_den   (d1_den[l][k+1]),
                    .o_quo   (d1_quo[l][k+1]),
                    .o_side  ()
                );
            end
        end
    end

    // ---------------- stage C: signed components
    t_d1_side                       c_in;
    logic [LANES-1:0][Q1_W-1:0]     c_abs;
    t_s2_side                       c_val;

    logic                           r_c_valid;
    logic [LANES-1:0][Q1_W-1:0]     r_c_abs;
    t_s2_side                       r_c_c;

    always_comb begin
        c_in = d1_side[Q1_W];
        for (int i = 0; i < LANES; i++) begin
            c_abs[i] = (c_in.own == t_own'(i)) ? c_in.own_c : d1_quo[i][Q1_W];
            c_val[i] = c_in.neg[i] ? (C_W'(0) - C_W'(c_abs[i])) : C_W'(c_abs[i]);
        end
    end

    // ---------------- stage D: squares; stage E: sum
    logic                           r_d_valid;
    logic [LANES-1:0][SQ2_W-1:0]    r_d_sq;
    t_s2_side                       r_d_c;
    logic                           r_e_valid;
    logic [SQ2_W-1:0]               r_e_sum;
    t_s2_side                       r_e_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= d1_valid[Q1_W];
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_abs <= c_abs;
            r_c_c   <= c_val;
            for (int i = 0; i < LANES; i++) begin
                r_d_sq[i] <= SQ2_W'(r_c_abs[i]) * SQ2_W'(r_c_abs[i]);
            end
            r_d_c   <= r_c_c;
            r_e_sum <= r_d_sq[0] + r_d_sq[1] + r_d_sq[2] + r_d_sq[3];
            r_e_c   <= r_d_c;
        end
    end

    // ---------------- norm root chain
    logic [R2_W:0]                  s2_valid;
    logic [R2_W:0][R2_W+1:0]        s2_rem;
    logic [R2_W:0][R2_W-1:0]        s2_root;
    logic [R2_W:0][SQ2_W-1:0]       s2_rad;
    t_s2_side                       s2_side [R2_W+1];

    assign s2_valid[0] = r_e_valid;
    assign s2_rem[0]   = '0;
    assign s2_root[0]  = '0;
    assign s2_rad[0]   = r_e_sum;
    assign s2_side[0]  = r_e_c;

    for (genvar k = 0; k < R2_W; k++) begin : g_s2
        rmq_sqrt_cell #(.W(SQ2_W), .t_side(t_s2_side)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s2_valid[k]),
            .i_rem   (s2_rem[k]),
            .i_root  (s2_root[k]),
            .i_rad   (s2_rad[k]),
            .i_side  (s2_side[k]),
            .o_valid (s2_valid[k+1]),
            .o_rem   (s2_rem[k+1]),
            .o_root  (s2_root[k+1]),
            .o_rad   (s2_rad[k+1]),
            .o_side  (s2_side[k+1])
        );
    end

    // ---------------- stage F: normalize operands
    t_s2_side                       f_c;
    logic [R2_W-1:0]                norm;
    logic [LANES-1:0]               f_neg;
    logic [LANES-1:0][C_W-1:0]      f_abs;
    logic [LANES-1:0][N2_W-1:0]     n_f_numer;

    logic                           r_f_valid;
    logic [LANES-1:0][N2_W-1:0]     r_f_numer;
    logic [D2_W-1:0]                r_f_den;
    t_d2_side                       r_f_neg;

    always_comb begin
        f_c  = s2_side[R2_W];
        norm = s2_root[R2_W];
        for (int i = 0; i < LANES; i++) begin
            f_neg[i]     = f_c[i][C_W-1];
            f_abs[i]     = f_neg[i] ? (C_W'(0) - f_c[i]) : f_c[i];
            // |c| * 2 * ONE + norm, over 2 * norm
            n_f_numer[i] = {f_abs[i][Q1_W-1:0], {(FRAC_BITS + 1){1'b0}}} + N2_W'(norm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= s2_valid[R2_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_numer <= n_f_numer;
            r_f_den   <= {norm, 1'b0};
            r_f_neg   <= f_neg;
        end
    end

    // ---------------- normalizing divide chains
    logic [Q2_W:0]                        d2_valid;
    logic [LANES-1:0][Q2_W:0][D2_W-1:0]   d2_rem;
    logic [LANES-1:0][Q2_W:0][Q2_W-1:0]   d2_num;
    logic [LANES-1:0][Q2_W:0][D2_W-1:0]   d2_den;
    logic [LANES-1:0][Q2_W:0][Q2_W-1:0]   d2_quo;
    t_d2_side                             d2_side [Q2_W+1];

    assign d2_valid[0] = r_f_valid;
    assign d2_side[0]  = r_f_neg;

    for (genvar l = 0; l < LANES; l++) begin : g_d2_lane
        assign d2_rem[l][0] = D2_W'(r_f_numer[l][N2_W-1:Q2_W]);
        assign d2_num[l][0] = r_f_numer[l][Q2_W-1:0];
        assign d2_den[l][0] = r_f_den;
        assign d2_quo[l][0] = '0;
        for (genvar k = 0; k < Q2_W; k++) begin : g_cell
            if (l == 0) begin : g_lead
                rmq_div_cell #(.Q(Q2_W), .DW(D2_W), .t_side(t_d2_side)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (en),
                    .i_valid (d2_valid[k]),
                    .i_rem   (d2_rem[l][k]),
                    .i_num   (d2_num[l][k]),
                    .i_den   (d2_den[l][k]),
                    .i_quo   (d2_quo[l][k]),
                    .i_side  (d2_side[k]),
                    .o_valid (d2_valid[k+1]),
                    .o_rem   (d2_rem[l][k+1]),
                    .o_num   (d2_num[l][k+1]),
                    .o_den   (d2_den[l][k+1]),
                    .o_quo   (d2_quo[l][k+1]),
                    .o_side  (d2_side[k+1])
                );
            end else begin : g_plain
                rmq_div_cell #(.Q(Q2_W), .DW(D2_W), .t_side(logic)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (en),
                    .i_valid (d2_valid[k]),
                    .i_rem   (d2_rem[l][k]),
                    .i_num   (d2_num[l][k]),
                    .i_den   (d2_den[l][k]),
                    .i_quo   (d2_quo[l][k]),
                    .i_side  (1'b0),
                    .o_valid (),
                    .o_rem   (d2_rem[l][k+1]),
                    .o_num   (d2_num[l][k+1]),
                    .o_den   (d2_den[l][k+1]),
                    .o_quo   (d2_quo[l][k+1]),
                    .o_side  ()
                );
            end
        end
    end

    // ---------------- stage G: sign, saturate, output word
    t_d2_side                         g_neg;
    logic [LANES-1:0][Q2_W-1:0]       g_mag;
    logic [LANES-1:0][OUT_W-1:0]      g_out;
    t_quat                            n_quat;

    logic                             r_g_valid;
    t_quat                            r_g_quat;

    always_comb begin
        g_neg = d2_side[Q2_W];
        for (int i = 0; i < LANES; i++) begin
            g_mag[i] = (d2_quo[i][Q2_W] > SAT_MAG) ? SAT_MAG : d2_quo[i][Q2_W];
            g_out[i] = g_neg[i] ? (OUT_W'(0) - OUT_W'(g_mag[i])) : OUT_W'(g_mag[i]);
        end
        n_quat.quat_w = g_out[0];
        n_quat.quat_x = g_out[1];
        n_quat.quat_y = g_out[2];
        n_quat.quat_z = g_out[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= d2_valid[Q2_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_quat <= n_quat;
        end
    end

    // pipeline moves whenever the output word is free or being taken;
    // no word is taken while in reset
    assign en            = !r_g_valid || o_quat.ready;
    assign i_mat.ready   = en && i_rst_n;
    assign o_quat.valid  = r_g_valid;
    assign o_quat.data   = r_g_quat;

endmodule
